// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the project's RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// A check that also runs while reset is asserted.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/u8t_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 package
// Types and constants shared by the transmitter, receiver and top level.
// ----------------------------------------------------------------------------
package u8t_pkg;

   localparam int DataBits    = 8;
   localparam int PeriodWidth = 16;
   localparam int RxTimerWidth = PeriodWidth + 1;
   localparam int CountWidth  = 4;

   localparam logic [PeriodWidth-1:0] PeriodReset = 16'd104;

   localparam logic [2:0] RegBitPeriod = 3'd0;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_result_type;

   typedef struct packed {
      logic                valid;
      logic [DataBits-1:0] data;
   } rx_result_type;

   function automatic logic [PeriodWidth-1:0] eff_period(input logic [PeriodWidth-1:0] period);
      eff_period = (period == '0) ? PeriodWidth'(1) : period;
   endfunction

endpackage

// ===== sv/u8t_tx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 transmitter
// Advances the transmit frame by one tick for every accepted transaction.
// ----------------------------------------------------------------------------
module u8t_tx
   import u8t_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [PeriodWidth-1:0] period,
   input  logic                   tx_start,
   input  logic [DataBits-1:0]    tx_byte,
   output tx_result_type          result
);

   phase_type               phase_ff, phase_in, phase_cur;
   logic [DataBits-1:0]     shift_ff, shift_in, shift_cur;
   logic [CountWidth-1:0]   bits_ff, bits_in, bits_cur, bits_dec;
   logic [PeriodWidth-1:0]  timer_ff, timer_in, timer_cur, timer_dec;

   always_comb begin
      phase_cur = phase_ff;
      shift_cur = shift_ff;
      bits_cur  = bits_ff;
      timer_cur = timer_ff;
      if (phase_ff == PH_IDLE && tx_start) begin
         phase_cur = PH_START;
         shift_cur = tx_byte;
         bits_cur  = CountWidth'(DataBits);
         timer_cur = eff_period(period);
      end

      case (phase_cur)
         PH_START: result.line = 1'b0;
         PH_DATA:  result.line = shift_cur[0];
         default:  result.line = 1'b1;
      endcase
      result.busy = (phase_cur != PH_IDLE);

      timer_dec = timer_cur - PeriodWidth'(1);
      bits_dec  = bits_cur - CountWidth'(1);
      phase_in  = phase_cur;
      shift_in  = shift_cur;
      bits_in   = bits_cur;
      timer_in  = timer_cur;
      if (phase_cur != PH_IDLE) begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            case (phase_cur)
               PH_START: begin
                  phase_in = PH_DATA;
                  timer_in = eff_period(period);
               end
               PH_DATA: begin
                  shift_in = shift_cur >> 1;
                  bits_in  = bits_dec;
                  phase_in = (bits_dec == '0) ? PH_STOP : PH_DATA;
                  timer_in = eff_period(period);
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         bits_ff  <= '0;
         timer_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         timer_ff <= timer_in;
      end
   end

endmodule

// ===== sv/u8t_rx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 receiver
// Detects the start bit, samples the data bits mid-bit and reports each byte.
// ----------------------------------------------------------------------------
module u8t_rx
   import u8t_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [PeriodWidth-1:0] period,
   input  logic                   rx_line,
   output rx_result_type          result
);

   phase_type                phase_ff, phase_in;
   logic [DataBits-1:0]      shift_ff, shift_in;
   logic [DataBits-1:0]      last_ff, last_in;
   logic [CountWidth-1:0]    count_ff, count_in, count_inc;
   logic [RxTimerWidth-1:0]  timer_ff, timer_in, timer_dec;
   logic [PeriodWidth-1:0]   period_eff;

   always_comb begin
      period_eff = eff_period(period);
      timer_dec  = timer_ff - RxTimerWidth'(1);
      count_inc  = count_ff + CountWidth'(1);
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      timer_in   = timer_ff;
      last_in    = last_ff;
      result.valid = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (!rx_line) begin
            phase_in = PH_DATA;
            shift_in = '0;
            count_in = '0;
            timer_in = RxTimerWidth'(period_eff >> 1) + RxTimerWidth'(period_eff);
         end
      end else begin
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (phase_ff == PH_DATA) begin
               shift_in = {rx_line, shift_ff[DataBits-1:1]};
               count_in = count_inc;
               if (count_inc >= CountWidth'(DataBits)) begin
                  phase_in = PH_STOP;
               end
               timer_in = RxTimerWidth'(period_eff);
            end else begin
               phase_in     = PH_IDLE;
               last_in      = shift_ff;
               result.valid = 1'b1;
            end
         end
      end
      result.data = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         count_ff <= '0;
         timer_ff <= '0;
         last_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         timer_ff <= timer_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== sv/uart_8n1_transceiver.sv =====
`timescale 1ns / 1ps
// Latency: a result appears in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle while rsp_tready holds; the result register frees as taken.
// The rate is set by the single result register behind the tick logic.
// Reset clears both frames to idle, the last byte to zero and bit_period to 104.
// ----------------------------------------------------------------------------
// UART 8N1 transceiver
// Stream-driven transmitter and receiver with an APB-style bit period register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_8n1_transceiver
   import u8t_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_line, tx_start, tx_byte[7:0], zero padding
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tx_line, tx_busy, rx_valid, rx_byte[7:0], zero padding
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                   req_accept;
   logic                   csr_write;
   logic [PeriodWidth-1:0] period_ff, period_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_data_ff, rsp_data_in;
   tx_result_type          tx_result;
   rx_result_type          rx_result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == RegBitPeriod[2]);
   assign csr_prdata = (csr_paddr[2] == RegBitPeriod[2]) ? {16'b0, period_ff} : 32'b0;
   assign period_in  = csr_write ? csr_pwdata[PeriodWidth-1:0] : period_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   u8t_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .step     (req_accept),
      .period   (period_ff),
      .tx_start (req_tdata[1]),
      .tx_byte  (req_tdata[9:2]),
      .result   (tx_result)
   );

   u8t_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .step    (req_accept),
      .period  (period_ff),
      .rx_line (req_tdata[0]),
      .result  (rx_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, rx_result.data, rx_result.valid, tx_result.busy,
                         tx_result.line};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PeriodReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_tvalid)
   `ASSERT_SAME(a_idle_line_high, clock, reset, rsp_tvalid && !rsp_tdata[1], rsp_tdata[0])
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_tvalid)

endmodule

// ===== sim/uart_8n1_transceiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 transceiver testbench
// Streams time ticks into the transceiver and checks every pin transaction
// against a cycle-accurate line predictor. It sends serial frames on the
// receive pin, along with broken frames and noise, and issues random transmit
// requests. The bit period is changed between phases, and both stream sides
// stall at random.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_tb;
   import u8t_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_start;
      logic       rx_line;
   } tick_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       tx_busy;
      logic       tx_line;
   } pins_type;

   localparam int TickPad       = 16 - $bits(tick_type);
   localparam int PinBits       = $bits(pins_type);
   localparam int GapMax        = 9;
   localparam int LongHold      = 60;
   localparam int WatchdogLimit = 2000;
   localparam int PhaseTicks    = 160;

   class uart_line_checker;
      logic [PeriodWidth-1:0]  bit_period;
      phase_type               tx_phase;
      phase_type               rx_phase;
      logic [7:0]              tx_shift;
      logic [7:0]              rx_shift;
      logic [7:0]              rx_held;
      logic [CountWidth-1:0]   tx_left;
      logic [CountWidth-1:0]   rx_count;
      logic [PeriodWidth-1:0]  tx_timer;
      logic [RxTimerWidth-1:0] rx_timer;
      pins_type                pins_due[$];
      int                      errors;
      int                      ticks;
      int                      frames_in;
      int                      frames_out;

      function new();
         bit_period = PeriodReset;
         tx_phase   = PH_IDLE;
         rx_phase   = PH_IDLE;
         tx_shift   = '0;
         rx_shift   = '0;
         rx_held    = '0;
         tx_left    = '0;
         rx_count   = '0;
         tx_timer   = '0;
         rx_timer   = '0;
         errors     = 0;
         ticks      = 0;
         frames_in  = 0;
         frames_out = 0;
      endfunction

      function void take_tick(tick_type t);
         logic [PeriodWidth-1:0] per;
         pins_type               p;
         per = (bit_period == '0) ? PeriodWidth'(1) : bit_period;
         p = '0;
         if (tx_phase == PH_IDLE && t.tx_start) begin
            tx_shift = t.tx_byte;
            tx_left  = CountWidth'(DataBits);
            tx_phase = PH_START;
            tx_timer = per;
            frames_out++;
         end
         p.tx_line = (tx_phase == PH_START) ? 1'b0 :
                     (tx_phase == PH_DATA)  ? tx_shift[0] : 1'b1;
         p.tx_busy = (tx_phase != PH_IDLE);
         if (tx_phase != PH_IDLE) begin
            tx_timer = tx_timer - 1'b1;
            if (tx_timer == '0) begin
               case (tx_phase)
                  PH_START: tx_phase = PH_DATA;
                  PH_DATA: begin
                     tx_shift = tx_shift >> 1;
                     tx_left  = tx_left - 1'b1;
                     if (tx_left == '0)
                        tx_phase = PH_STOP;
                  end
                  default: tx_phase = PH_IDLE;
               endcase
               tx_timer = per;
            end
         end
         if (rx_phase == PH_IDLE) begin
            if (!t.rx_line) begin
               rx_phase = PH_DATA;
               rx_shift = '0;
               rx_count = '0;
               rx_timer = RxTimerWidth'(per) + RxTimerWidth'(per >> 1);
            end
         end else begin
            rx_timer = rx_timer - 1'b1;
            if (rx_timer == '0) begin
               if (rx_phase == PH_DATA) begin
                  rx_shift = {t.rx_line, rx_shift[7:1]};
                  rx_count = rx_count + 1'b1;
                  if (rx_count >= DataBits)
                     rx_phase = PH_STOP;
                  rx_timer = RxTimerWidth'(per);
               end else begin
                  rx_phase   = PH_IDLE;
                  rx_held    = rx_shift;
                  p.rx_valid = 1'b1;
                  frames_in++;
               end
            end
         end
         p.rx_byte = rx_held;
         pins_due.push_back(p);
         ticks++;
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_pins(logic [15:0] data);
         pins_type got;
         pins_type want;
         got = data[PinBits-1:0];
         if (pins_due.size() == 0) begin
            $display("%t: unexpected result transaction, expected none, actual %h",
                     $time, data);
            errors++;
            return;
         end
         want = pins_due.pop_front();
         compare("tx_line", 16'(want.tx_line), 16'(got.tx_line));
         compare("tx_busy", 16'(want.tx_busy), 16'(got.tx_busy));
         compare("rx_valid", 16'(want.rx_valid), 16'(got.rx_valid));
         compare("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
         compare("padding", 16'h0, 16'(data[15:PinBits]));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   uart_line_checker line_checker;
   bit               offering;
   bit               req_burst;
   bit               rsp_burst;
   bit               long_hold_pending;
   int               stall_cycles;
   int               settings;

   uart_8n1_transceiver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         line_checker.check_pins(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("%t: no transaction for %0d cycles", $time, stall_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : result_side
      int gap;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            gap = LongHold;
            long_hold_pending = 1'b0;
         end else begin
            gap = rsp_burst ? 0 : $urandom_range(0, GapMax);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_tick(input tick_type t);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, GapMax);
      if (gap > 0 && offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{TickPad{1'b0}}, t};
      offering = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      line_checker.take_tick(t);
   endtask

   task automatic hold_line(input logic level, input int count);
      tick_type t;
      repeat (count) begin
         t.rx_line  = level;
         t.tx_start = ($urandom_range(0, 5) == 0);
         t.tx_byte  = pick_byte();
         send_tick(t);
      end
   endtask

   task automatic send_frame(input logic [7:0] value, input int bits_sent);
      int per;
      per = (line_checker.bit_period == '0) ? 1 : int'(line_checker.bit_period);
      hold_line(1'b0, per);
      for (int i = 0; i < bits_sent; i++)
         hold_line(value[i], per);
      if (bits_sent == DataBits)
         hold_line(1'b1, per);
      hold_line(1'b1, $urandom_range(0, 3 * per));
   endtask

   task automatic run_frames(input int length);
      int first;
      int r;
      int per;
      first = line_checker.ticks;
      per = (line_checker.bit_period == '0) ? 1 : int'(line_checker.bit_period);
      while (line_checker.ticks - first < length) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            send_frame(pick_byte(), DataBits);
         end else if (r == 7) begin
            send_frame(pick_byte(), $urandom_range(1, DataBits - 1));
         end else if (r == 8) begin
            hold_line(1'b0, $urandom_range(1, per));
            hold_line(1'b1, $urandom_range(1, 4 * per));
         end else begin
            repeat ($urandom_range(1, 8)) hold_line(1'($urandom_range(0, 1)), 1);
         end
      end
   endtask

   task automatic drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      do @(posedge clock); while (line_checker.pins_due.size() != 0);
   endtask

   task automatic csr_access(input logic write, input logic [PeriodWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= RegBitPeriod;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (write) begin
         line_checker.bit_period = value;
         settings++;
      end else if (csr_prdata !== 32'(line_checker.bit_period)) begin
         $display("%t: bit_period read mismatch, expected %h, actual %h",
                  $time, 32'(line_checker.bit_period), csr_prdata);
         line_checker.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [PeriodWidth-1:0] periods [10];
      periods = '{16'd2, 16'd3, 16'd0, 16'd5, 16'd1, 16'd2, 16'd4, 16'd8, 16'd6, 16'd3};
      line_checker = new();
      offering = 1'b0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      long_hold_pending = 1'b0;
      settings = 1;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      stall_cycles <= 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0);

      // A transmit request with all ones, a second one while busy that must be ignored,
      // then a receive start edge and a low level while the receiver is already running.
      send_tick('{tx_byte: 8'hFF, tx_start: 1'b1, rx_line: 1'b1});
      send_tick('{tx_byte: 8'h00, tx_start: 1'b1, rx_line: 1'b1});
      send_tick('{tx_byte: 8'h00, tx_start: 1'b1, rx_line: 1'b0});
      for (int i = 0; i < 20; i++)
         send_tick('{tx_byte: (i % 2 == 0) ? 8'hAA : 8'h55, tx_start: 1'b0,
                     rx_line: (i == 9) ? 1'b0 : 1'b1});

      // The first period change below lands while both directions are still part way through a bit.
      for (int k = 0; k < 10; k++) begin
         drain();
         csr_access(1'b1, periods[k]);
         req_burst = (k % 3 == 1);
         rsp_burst = (k % 4 == 2);
         if (k == 3)
            long_hold_pending = 1'b1;
         if (k == 4) begin
            run_frames(PhaseTicks / 2);
            drain();
            run_frames(PhaseTicks / 2);
         end else begin
            run_frames(PhaseTicks);
         end
      end

      drain();
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      csr_access(1'b1, 16'hFFFF);
      csr_access(1'b0, '0);
      repeat (30) hold_line(1'($urandom_range(0, 1)), 1);

      drain();
      repeat (4) @(posedge clock);
      $display("Run covered %0d tick transactions over %0d bit period settings,",
               line_checker.ticks, settings);
      $display("with %0d frames received and %0d transmit requests taken.",
               line_checker.frames_in, line_checker.frames_out);
      if (line_checker.errors == 0 && line_checker.pins_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
